// File: rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared sizes, operation codes and status codes of the indexed list store.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 16;
    localparam int DATA_W   = 32;
    localparam int LEN_W    = 7;
    localparam int OP_W     = 3;
    localparam int ST_W     = 2;
    // compare width for index against count
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_REMOVE = 3'd2,
        OP_GET    = 3'd3,
        OP_SET    = 3'd4,
        OP_SIZE   = 3'd5,
        OP_CLEAR  = 3'd6
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

endpackage

// File: rtl/indexed_list_store_core.sv
// ----------------------------------------------------------------------------
// indexed_list_store_core
// Ordered list of signed 32-bit words with append, indexed insert and remove,
// get, set, size and clear, kept in a single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_ready is high only while the sequencer is
// idle, and a finished result waits in the output register while the next
// item is taken. Set, size, clear, the unused code, removing the last
// element, removing index 0 of an empty list and every rejected operation
// go straight to the result state; get passes through a read state first;
// append and insert at the end write the new word directly, and insert below
// the end first moves each word from the end down to index i one slot up by
// a read and a write, then writes the new word. Remove moves each word above
// index i one slot down the same way. A finished result waits in the result
// state while the receiver stalls the output register. in_ready rises on the
// load edge. The element RAM moves one word per read/write pair while the
// address counter walks the shifted span.
module indexed_list_store_core
    import ils_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OP_W-1:0]          op,
    input  logic signed [POS_W-1:0]  position,
    input  logic signed [DATA_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] read_value,
    output logic [ST_W-1:0]          status,
    output logic [LEN_W-1:0]         length
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_INS_FILL,
        S_REM_RD,
        S_REM_WR,
        S_GET,
        S_POST
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [ADDR_W-1:0]   ptr_reg;
    logic [ADDR_W-1:0]   idx_reg;
    logic [DATA_W-1:0]   val_reg;
    logic [DATA_W-1:0]   res_value_reg;
    status_t             res_status_reg;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_value_reg;
    status_t             out_status_reg;
    logic [LEN_W-1:0]    out_length_reg;

    logic [DATA_W-1:0]   mem [CAPACITY];
    logic [DATA_W-1:0]   rd_data_reg;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [ADDR_W-1:0]   mem_raddr;

    logic                accept;
    logic                pos_neg;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic [CMP_W-1:0]    ptr_p1_ext;
    logic                below;
    logic                ins_ok;
    logic                full;
    logic [ADDR_W-1:0]   pos_addr;
    logic [ADDR_W-1:0]   cnt_addr;
    logic [ADDR_W-1:0]   cnt_m1_addr;
    logic                out_free;

    // Decode the incoming index against the current count
    assign accept      = in_valid && in_ready;
    assign in_ready    = (state_reg == S_IDLE);
    assign pos_neg     = position[POS_W-1];
    assign pos_ext     = CMP_W'($unsigned(position));
    assign cnt_ext     = CMP_W'(count_reg);
    assign ptr_p1_ext  = CMP_W'(ptr_reg) + CMP_W'(1);
    assign below       = !pos_neg && (pos_ext < cnt_ext);
    assign ins_ok      = !pos_neg && (pos_ext <= cnt_ext);
    assign full        = (cnt_ext >= CMP_W'(CAPACITY));
    assign pos_addr    = position[ADDR_W-1:0];
    assign cnt_addr    = count_reg[ADDR_W-1:0];
    assign cnt_m1_addr = cnt_addr - ADDR_W'(1);
    assign out_free    = !out_valid_reg || out_ready;

    // Drive the RAM ports from the sequencer state
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ptr_reg;
        mem_wdata = rd_data_reg;
        mem_raddr = ptr_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                mem_raddr = pos_addr;
                mem_waddr = pos_addr;
                mem_wdata = value;
                mem_we    = accept && (op == OP_SET) && below;
            end
            S_INS_RD:
            begin
                mem_raddr = ptr_reg;
            end
            S_INS_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg + ADDR_W'(1);
                mem_wdata = rd_data_reg;
            end
            S_INS_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = val_reg;
            end
            S_REM_RD:
            begin
                mem_raddr = ptr_reg + ADDR_W'(1);
            end
            S_REM_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = rd_data_reg;
            end
            S_GET, S_POST:
            begin
                mem_we = 1'b0;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Element RAM: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // Sequencer, count and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            ptr_reg        <= '0;
            idx_reg        <= '0;
            val_reg        <= '0;
            res_value_reg  <= '0;
            res_status_reg <= ST_OK;
            out_value_reg  <= '0;
            out_status_reg <= ST_OK;
            out_length_reg <= '0;
        end
        else
        begin
            // drop the result once taken, unless a new one loads in its place
            if (out_valid_reg && out_ready && !((state_reg == S_POST) && out_free))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        res_value_reg <= '0;
                        val_reg       <= value;
                        unique case (op)
                            OP_APPEND, OP_INSERT:
                            begin
                                if ((op == OP_INSERT) && !ins_ok)
                                begin
                                    res_status_reg <= ST_BAD_INDEX;
                                    state_reg      <= S_POST;
                                end
                                else if (full)
                                begin
                                    res_status_reg <= ST_FULL;
                                    state_reg      <= S_POST;
                                end
                                else
                                begin
                                    res_status_reg <= ST_OK;
                                    count_reg <= count_reg + CNT_W'(1);
                                    idx_reg   <= (op == OP_APPEND) ? cnt_addr : pos_addr;
                                    ptr_reg   <= cnt_m1_addr;
                                    if ((op == OP_APPEND) || (pos_ext == cnt_ext))
                                    begin
                                        state_reg <= S_INS_FILL;
                                    end
                                    else
                                    begin
                                        state_reg <= S_INS_RD;
                                    end
                                end
                            end
                            OP_REMOVE:
                            begin
                                if ((pos_ext == '0) && (count_reg == '0))
                                begin
                                    res_status_reg <= ST_OK;
                                    state_reg      <= S_POST;
                                end
                                else if (!below)
                                begin
                                    res_status_reg <= ST_BAD_INDEX;
                                    state_reg      <= S_POST;
                                end
                                else
                                begin
                                    res_status_reg <= ST_OK;
                                    count_reg <= count_reg - CNT_W'(1);
                                    ptr_reg   <= pos_addr;
                                    // removing the last element moves nothing
                                    if (pos_ext + CMP_W'(1) != cnt_ext)
                                    begin
                                        state_reg <= S_REM_RD;
                                    end
                                    else
                                    begin
                                        state_reg <= S_POST;
                                    end
                                end
                            end
                            OP_GET:
                            begin
                                if (below)
                                begin
                                    res_status_reg <= ST_OK;
                                    state_reg      <= S_GET;
                                end
                                else
                                begin
                                    res_status_reg <= ST_BAD_INDEX;
                                    state_reg      <= S_POST;
                                end
                            end
                            OP_SET:
                            begin
                                if (!below)
                                begin
                                    res_status_reg <= ST_BAD_INDEX;
                                end
                                else
                                begin
                                    res_status_reg <= ST_OK;
                                end
                                state_reg <= S_POST;
                            end
                            OP_CLEAR:
                            begin
                                res_status_reg <= ST_OK;
                                count_reg      <= '0;
                                state_reg      <= S_POST;
                            end
                            default:
                            begin
                                res_status_reg <= ST_OK;
                                state_reg      <= S_POST;
                            end
                        endcase
                    end
                end
                S_INS_RD:
                begin
                    state_reg <= S_INS_WR;
                end
                S_INS_WR:
                begin
                    // walk down until the insert point has been vacated
                    if (ptr_reg == idx_reg)
                    begin
                        state_reg <= S_INS_FILL;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg - ADDR_W'(1);
                        state_reg <= S_INS_RD;
                    end
                end
                S_INS_FILL:
                begin
                    state_reg <= S_POST;
                end
                S_REM_RD:
                begin
                    state_reg <= S_REM_WR;
                end
                S_REM_WR:
                begin
                    // count already holds the new length
                    if (ptr_p1_ext == cnt_ext)
                    begin
                        state_reg <= S_POST;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg + ADDR_W'(1);
                        state_reg <= S_REM_RD;
                    end
                end
                S_GET:
                begin
                    res_value_reg <= rd_data_reg;
                    state_reg     <= S_POST;
                end
                S_POST:
                begin
                    // hold until the output register is free
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_value_reg  <= res_value_reg;
                        out_status_reg <= res_status_reg;
                        out_length_reg <= cnt_ext[LEN_W-1:0];
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_value_reg;
    assign status     = out_status_reg;
    assign length     = out_length_reg;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(CAPACITY))
        else $error("element count above capacity");

    a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_FULL))
            |-> (out_length_reg == LEN_W'(CAPACITY)))
        else $error("full status without a full store");

    a_read_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_value_reg != '0)) |-> (out_status_reg == ST_OK))
        else $error("read data returned with an error status");

    a_post_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_POST) && out_free) |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("finished result not loaded into output register");
`endif

endmodule

// File: tb/indexed_list_store_checker.sv
// ----------------------------------------------------------------------------
// indexed_list_store_checker
// Watches both channels of the indexed list store, keeps its own copy of the
// list, predicts one result per accepted operation and compares every result
// field by field, in order.
// ----------------------------------------------------------------------------
module indexed_list_store_checker
    import ils_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic [OP_W-1:0]          op,
    input  logic signed [POS_W-1:0]  position,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [DATA_W-1:0] read_value,
    input  logic [ST_W-1:0]          status,
    input  logic [LEN_W-1:0]         length,
    output int                       fail_count,
    output int                       pending,
    output int                       list_length,
    output int                       results_checked,
    output int                       full_rejects,
    output int                       bad_index_hits
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic [ST_W-1:0]          stat;
        logic [LEN_W-1:0]         len;
    } list_result_t;

    // Shadow list and the results still owed by the block
    logic signed [DATA_W-1:0] list_words [CAPACITY];
    int                       word_count;
    list_result_t             expected_results [$];
    list_result_t             want;

    int mismatch_total = 0;
    int checked_total  = 0;
    int full_total     = 0;
    int bad_total      = 0;

    assign fail_count      = mismatch_total;
    assign results_checked = checked_total;
    assign full_rejects    = full_total;
    assign bad_index_hits  = bad_total;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] exp_val);
        $display("t=%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
        mismatch_total++;
    endtask

    // Apply one operation to the shadow list and return the result it owes
    function automatic list_result_t apply_list_op(input logic [OP_W-1:0] code,
                                                   input logic signed [POS_W-1:0] pos,
                                                   input logic signed [DATA_W-1:0] word);
        list_result_t res;
        int           idx;
        bit           in_list;
        res.data = '0;
        res.stat = ST_OK;
        idx      = int'(pos);
        in_list  = (idx >= 0) && (idx < word_count);
        case (op_t'(code))
            OP_APPEND:
            begin
                if (word_count >= CAPACITY)
                    res.stat = ST_FULL;
                else
                begin
                    list_words[word_count] = word;
                    word_count++;
                end
            end
            OP_INSERT:
            begin
                // index is checked before capacity
                if (idx < 0 || idx > word_count)
                    res.stat = ST_BAD_INDEX;
                else if (word_count >= CAPACITY)
                    res.stat = ST_FULL;
                else
                begin
                    for (int k = word_count; k > idx; k--)
                        list_words[k] = list_words[k-1];
                    list_words[idx] = word;
                    word_count++;
                end
            end
            OP_REMOVE:
            begin
                // removing the head of an empty list is accepted and does nothing
                if (idx == 0 && word_count == 0)
                    res.stat = ST_OK;
                else if (!in_list)
                    res.stat = ST_BAD_INDEX;
                else
                begin
                    for (int k = idx; k < word_count - 1; k++)
                        list_words[k] = list_words[k+1];
                    word_count--;
                end
            end
            OP_GET:
            begin
                if (in_list)
                    res.data = list_words[idx];
                else
                    res.stat = ST_BAD_INDEX;
            end
            OP_SET:
            begin
                if (in_list)
                    list_words[idx] = word;
                else
                    res.stat = ST_BAD_INDEX;
            end
            OP_CLEAR:
            begin
                word_count = 0;
            end
            default:
            begin
                // size query and the unused code change nothing
            end
        endcase
        res.len = LEN_W'(word_count);
        return res;
    endfunction

    // Check each result transfer, then predict each operation transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count = 0;
            expected_results.delete();
            pending     <= 0;
            list_length <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing outstanding", read_value, '0);
                else
                begin
                    want = expected_results.pop_front();
                    checked_total++;
                    if (want.stat == ST_FULL)
                        full_total++;
                    if (want.stat == ST_BAD_INDEX)
                        bad_total++;
                    if (read_value !== want.data)
                        report_mismatch("read_value", read_value, want.data);
                    if (status !== want.stat)
                        report_mismatch("status", DATA_W'(status), DATA_W'(want.stat));
                    if (length !== want.len)
                        report_mismatch("length", DATA_W'(length), DATA_W'(want.len));
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_list_op(op, position, value));
            pending     <= expected_results.size();
            list_length <= word_count;
        end
    end

endmodule

// File: tb/indexed_list_store_core_tb.sv
// ----------------------------------------------------------------------------
// indexed_list_store_core_tb
// Drives directed and random list operations into the indexed list store with
// random idling on both channels, a long output stall and a full drain pause;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module indexed_list_store_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ils_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam int RANDOM_ITEMS = 1930;
    localparam int HOLD_AT      = 500;
    localparam int PAUSE_AT     = 1100;
    localparam int TAIL_ITEMS   = 200;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 150;
    localparam int IDLE_LIMIT   = 4000;

    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED, MIX_NOISE} traffic_mix_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [OP_W-1:0]          op;
    logic signed [POS_W-1:0]  position;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] read_value;
    logic [ST_W-1:0]          status;
    logic [LEN_W-1:0]         length;

    int   fail_count;
    int   pending;
    int   list_length;
    int   results_checked;
    int   full_rejects;
    int   bad_index_hits;

    logic hold_req;
    logic quiet_tail;
    int   items_sent;
    int   idle_cycles;

    indexed_list_store_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_value (read_value),
        .status     (status),
        .length     (length)
    );

    indexed_list_store_checker list_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .position        (position),
        .value           (value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_value      (read_value),
        .status          (status),
        .length          (length),
        .fail_count      (fail_count),
        .pending         (pending),
        .list_length     (list_length),
        .results_checked (results_checked),
        .full_rejects    (full_rejects),
        .bad_index_hits  (bad_index_hits)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hold reset low at the start, then release it for good
    initial
    begin
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Offer one operation and hold it until the transfer
    task automatic send_item(input logic [OP_W-1:0] code, input int pos,
                             input logic signed [DATA_W-1:0] word);
        op       <= code;
        position <= POS_W'(pos);
        value    <= word;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Pick an operation according to the current traffic mix
    function automatic logic [OP_W-1:0] pick_op(input traffic_mix_t mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:
            begin
                if (r < 40) return OP_APPEND;
                if (r < 75) return OP_INSERT;
                if (r < 82) return OP_GET;
                if (r < 88) return OP_SET;
                if (r < 94) return OP_REMOVE;
                if (r < 99) return OP_SIZE;
                return OP_CLEAR;
            end
            MIX_SHRINK:
            begin
                if (r < 55) return OP_REMOVE;
                if (r < 70) return OP_GET;
                if (r < 80) return OP_SET;
                if (r < 88) return OP_APPEND;
                if (r < 95) return OP_INSERT;
                if (r < 99) return OP_SIZE;
                return OP_CLEAR;
            end
            MIX_BALANCED:
            begin
                if (r < 20) return OP_APPEND;
                if (r < 40) return OP_INSERT;
                if (r < 60) return OP_REMOVE;
                if (r < 75) return OP_GET;
                if (r < 90) return OP_SET;
                if (r < 95) return OP_SIZE;
                if (r < 98) return OP_CLEAR;
                return OP_UNUSED;
            end
            default:
            begin
                return OP_W'($urandom_range(0, 7));
            end
        endcase
    endfunction

    // Mostly legal indices; the list length seen here may trail by one transfer
    function automatic logic signed [POS_W-1:0] pick_position(input logic [OP_W-1:0] code,
                                                              input bit wild);
        int span;
        int r;
        int neg;
        span = (code == OP_INSERT) ? list_length : list_length - 1;
        if (span < 0)
            span = 0;
        r = $urandom_range(0, 99);
        if (wild || r >= 92)
            return POS_W'($urandom);
        if (r < 75)
            return POS_W'($urandom_range(0, span));
        if (r < 85)
        begin
            case ($urandom_range(0, 3))
                0:       return POS_W'(list_length);
                1:       return POS_W'(list_length + 1);
                2:       return POS_W'(-1);
                default: return '0;
            endcase
        end
        neg = -int'($urandom_range(1, 32768));
        return POS_W'(neg);
    endfunction

    // Random data word with the extremes mixed in
    function automatic logic signed [DATA_W-1:0] pick_word();
        if ($urandom_range(0, 9) != 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Result side: random stall bursts, one long hold-off, none in the tail
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(50, 150)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    initial
    begin
        idle_cycles = 0;
        wait (rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Operation stimulus and verdict
    initial
    begin
        traffic_mix_t             mix;
        bit                       calm;
        int                       seg_end;
        logic [OP_W-1:0]          code;
        logic signed [POS_W-1:0]  pos;
        logic signed [DATA_W-1:0] word;

        items_sent = 0;
        in_valid   <= 1'b0;
        op         <= OP_SIZE;
        position   <= '0;
        value      <= '0;
        hold_req   <= 1'b0;
        quiet_tail <= 1'b0;
        wait (rst_n);
        @(posedge clk);

        // Directed: empty-list corner cases
        send_item(OP_GET,    0,  32'h0);
        send_item(OP_REMOVE, 0,  32'h0);
        send_item(OP_REMOVE, -1, 32'h0);
        send_item(OP_SET,    0,  32'h1234_5678);
        send_item(OP_INSERT, 1,  32'h0);
        // Directed: build a short list with extreme words at both ends
        send_item(OP_INSERT, 0,  32'h7FFF_FFFF);
        send_item(OP_APPEND, 0,  32'h8000_0000);
        send_item(OP_INSERT, 2,  32'h0000_0000);
        send_item(OP_INSERT, 1,  32'hFFFF_FFFF);
        send_item(OP_INSERT, 5,  32'h0);
        // Directed: index extremes and reads
        send_item(OP_GET, -32768, 32'h0);
        send_item(OP_GET, 32767,  32'h0);
        send_item(OP_GET, 0,      32'h0);
        send_item(OP_GET, 3,      32'h0);
        send_item(OP_GET, 4,      32'h0);
        send_item(OP_SET, 3,      32'h5A5A_A5A5);
        send_item(OP_GET, 3,      32'h0);
        // Directed: removes at both ends, size, unused code, clear
        send_item(OP_REMOVE, 3, 32'h0);
        send_item(OP_REMOVE, 0, 32'h0);
        send_item(OP_SIZE,   0, 32'h0);
        send_item(OP_UNUSED, 7, 32'hDEAD_BEEF);
        send_item(OP_CLEAR,  0, 32'h0);
        send_item(OP_SIZE,   0, 32'h0);
        send_item(OP_GET,    0, 32'h0);

        // Random traffic in segments; start by filling the store
        mix     = MIX_GROW;
        calm    = 1'b0;
        seg_end = 150;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == seg_end)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2: mix = MIX_GROW;
                    3, 4:    mix = MIX_SHRINK;
                    5, 6, 7: mix = MIX_BALANCED;
                    default: mix = MIX_NOISE;
                endcase
                calm    = ($urandom_range(0, 2) == 0);
                seg_end = n + $urandom_range(40, 160);
            end
            if (n == HOLD_AT)
                hold_req <= 1'b1;
            if (n == RANDOM_ITEMS - TAIL_ITEMS)
                quiet_tail <= 1'b1;
            // Stop offering until every owed result has arrived
            if (n == PAUSE_AT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            code = pick_op(mix);
            pos  = pick_position(code, mix == MIX_NOISE);
            word = pick_word();
            send_item(code, int'(pos), word);
            if (!calm && n < RANDOM_ITEMS - TAIL_ITEMS && $urandom_range(0, 4) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
        end

        // Drain: wait for every owed result, then let the block settle
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d list operations, %0d results compared", items_sent,
                 results_checked);
        $display("Saw %0d store-full and %0d bad-index results, with a long output stall",
                 full_rejects, bad_index_hits);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
rtl/ils_pkg.sv
rtl/indexed_list_store_core.sv
tb/indexed_list_store_checker.sv
tb/indexed_list_store_core_tb.sv
